FILE: src/fnvbh_pkg.sv
// Package with the shared types and constants of the four-lane block hash.
package fnvbh_pkg;

  localparam int unsigned LANES = 4;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned IN_DATA_W = 136;
  localparam int unsigned OUT_DATA_W = 128;

  localparam logic [CNT_W-1:0] CHUNK_BYTES = 5'd16;

  localparam logic [WORD_W-1:0] SEED0 = 32'd2166136261;
  localparam logic [WORD_W-1:0] SEED1 = 32'd2246822519;
  localparam logic [WORD_W-1:0] SEED2 = 32'd3266489917;
  localparam logic [WORD_W-1:0] SEED3 = 32'd668265263;

  localparam logic [WORD_W-1:0] PRIME0 = 32'd16777619;
  localparam logic [WORD_W-1:0] PRIME1 = 32'd2246822519;
  localparam logic [WORD_W-1:0] PRIME2 = 32'd3266489917;
  localparam logic [WORD_W-1:0] PRIME3 = 32'd374761393;

  localparam logic [WORD_W-1:0] FNV_PRIME = 32'd16777619;

  localparam logic [WORD_W-1:0] MIX0 = 32'h9E3779B1;
  localparam logic [WORD_W-1:0] MIX2 = 32'h85EBCA77;
  localparam logic [WORD_W-1:0] MIX3 = 32'hC2B2AE3D;

  typedef logic [LANES-1:0][WORD_W-1:0] lanes_t;

  typedef struct packed {
    lanes_t           words;
    logic [CNT_W-1:0] cnt;
    logic             last;
    logic             full;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_FOLD = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  function automatic lanes_t seeds();
    lanes_t s;
    s[0] = SEED0;
    s[1] = SEED1;
    s[2] = SEED2;
    s[3] = SEED3;
    return s;
  endfunction

  function automatic lanes_t primes();
    lanes_t p;
    p[0] = PRIME0;
    p[1] = PRIME1;
    p[2] = PRIME2;
    p[3] = PRIME3;
    return p;
  endfunction

endpackage

FILE: src/fnvbh_front.sv
// Input side: unpacks a chunk transaction and classifies it for the queue.
module fnvbh_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fnvbh_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  input  fnvbh_pkg::q_status_t             q_status,
  output logic                             push,
  output fnvbh_pkg::item_t                 push_item
);
  import fnvbh_pkg::*;

  logic [CNT_W-1:0] raw_cnt;
  logic [CNT_W-1:0] sat_cnt;

  assign raw_cnt = in_tdata[LANES*WORD_W +: CNT_W];
  assign sat_cnt = (raw_cnt > CHUNK_BYTES) ? CHUNK_BYTES : raw_cnt;

  always_comb begin
    push_item.words = in_tdata[LANES*WORD_W-1:0];
    push_item.last  = in_tlast;
    push_item.cnt   = in_tlast ? sat_cnt : CHUNK_BYTES;
    push_item.full  = !in_tlast || (sat_cnt == CHUNK_BYTES);
  end

  assign in_tready = !q_status.full;
  assign push      = in_tvalid && in_tready;

endmodule

FILE: src/fnvbh_queue.sv
// Small queue of classified chunks between the front and the back.
module fnvbh_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fnvbh_pkg::item_t      push_item,
  input  logic                  pop,
  output fnvbh_pkg::item_t      head_item,
  output fnvbh_pkg::q_status_t  q_status,
  output logic [$clog2(DEPTH+1)-1:0] q_count
);
  import fnvbh_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  item_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign do_push = push && (count_r != FULL_CNT);
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item      = mem_r[rd_ptr_r];
  assign q_status.empty = (count_r == '0);
  assign q_status.full  = (count_r == FULL_CNT);
  assign q_count        = count_r;

endmodule

FILE: src/fnvbh_back.sv
// Back end: lane arithmetic, tail folding, length mixing and the result register.
module fnvbh_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fnvbh_pkg::item_t                 head_item,
  input  fnvbh_pkg::q_status_t             q_status,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fnvbh_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fnvbh_pkg::*;

  state_t             state_r, state_nxt;
  lanes_t             lane_r;
  lanes_t             prod_r;
  lanes_t             words_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               last_r;
  logic [WORD_W-1:0]  len_r;
  logic [2:0]         fold_r;
  logic               out_valid_r;
  lanes_t             out_data_r;

  logic [2:0]         head_folds;
  logic [2:0]         folds;
  logic [1:0]         nwords;
  logic [3:0]         byte_idx;
  logic [1:0]         fold_lane;
  logic [WORD_W-1:0]  fold_val;
  logic [WORD_W-1:0]  fold_res;
  logic               out_free;
  lanes_t             mix;
  lanes_t             prime_c;

  assign prime_c    = primes();
  assign head_folds = 3'(head_item.cnt[3:2]) + 3'(head_item.cnt[1:0]);
  assign nwords     = cnt_r[3:2];
  assign folds      = 3'(nwords) + 3'(cnt_r[1:0]);
  assign fold_lane  = fold_r[1:0];
  assign byte_idx   = {nwords, 2'b00} + 4'(fold_r - 3'(nwords));
  assign out_free   = !out_valid_r || out_tready;
  assign pop        = (state_r == ST_IDLE) && !q_status.empty;

  always_comb begin
    if (fold_r < 3'(nwords)) begin
      fold_val = words_r[fold_r[1:0]];
    end else begin
      fold_val = {24'd0, words_r[byte_idx[3:2]][{byte_idx[1:0], 3'b000} +: 8]};
    end
    fold_res = (lane_r[fold_lane] ^ fold_val) * FNV_PRIME;
  end

  always_comb begin
    mix[0] = lane_r[0] ^ (len_r * MIX0);
    mix[1] = lane_r[1] ^ {len_r[WORD_W-8:0], len_r[WORD_W-1:WORD_W-7]};
    mix[2] = lane_r[2] ^ (len_r * MIX2);
    mix[3] = lane_r[3] ^ (len_r * MIX3);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          if (head_item.full) begin
            state_nxt = ST_MUL;
          end else if (head_folds == '0) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_FOLD;
          end
        end
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: state_nxt = last_r ? ST_FIN : ST_IDLE;
      ST_FOLD: begin
        if (fold_r == folds - 3'd1) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lane_r      <= seeds();
      len_r       <= '0;
      fold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            len_r  <= len_r + WORD_W'(head_item.cnt);
            fold_r <= '0;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < LANES; i++) begin
            lane_r[i] <= prod_r[i] + words_r[(i + 1) % LANES];
          end
        end
        ST_FOLD: begin
          lane_r[fold_lane] <= fold_res;
          fold_r            <= fold_r + 3'd1;
        end
        ST_FIN: begin
          if (out_free) begin
            lane_r <= seeds();
            len_r  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      words_r <= head_item.words;
      cnt_r   <= head_item.cnt;
      last_r  <= head_item.last;
    end
    if (state_r == ST_MUL) begin
      for (int i = 0; i < LANES; i++) begin
        prod_r[i] <= (lane_r[i] ^ words_r[i]) * prime_c[i];
      end
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_data_r <= mix;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: src/four_lane_fnv_block_hash.sv
// Top level of the four-lane block hash: front, chunk queue and back end.
// A non-last chunk passes the back-end states dequeue, multiply and add, in that order.
// A full last chunk then goes to finish; a short one first folds its tail, if any.
// A new chunk is dequeued only in idle, so the back end handles one chunk at a time.
// Tail folds share one multiplier, one fold per cycle, up to six per message.
// Synchronous active-low reset loads lane seeds, clears length, queue, output valid.
module four_lane_fnv_block_hash #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // word0, word1, word2, word3, byte_count, zero pad
  input  logic [fnvbh_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // hash0, hash1, hash2, hash3
  output logic [fnvbh_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fnvbh_pkg::*;

  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  q_status_t          q_status;
  item_t              push_item;
  item_t              head_item;
  logic               push;
  logic               pop;
  logic [CNT_QW-1:0]  q_count;

  fnvbh_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  fnvbh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_status  (q_status),
    .q_count   (q_count)
  );

  fnvbh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_item  (head_item),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("Back end dequeued from an empty queue.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_QW'(QUEUE_DEPTH))
    else $error("Queue occupancy exceeds its depth.");

  a_fill_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !q_status.empty)
    else $error("Queue is empty right after an enqueue without a dequeue.");

  a_reset_out: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("Result valid after reset.");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the four-lane block hash: stream driver, predictor and monitor.
`timescale 1ns / 100ps

module testbench;
  import fnvbh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS = 400;

  typedef struct {
    lanes_t     words;
    logic [4:0] nbytes;
    logic       last;
    int         gap_pct;
    int         stall_pct;
    bit         drain_first;
  } chunk_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  chunk_t      chunk_q[$];
  lanes_t      digest_q[$];
  chunk_t      sent_chunk;
  lanes_t      lane_st;
  logic [31:0] len_st;
  int          stall_pct = 0;
  int          fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned chunks_queued = 0;

  four_lane_fnv_block_hash i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void reload_lanes();
    lane_st[0] = SEED0;
    lane_st[1] = SEED1;
    lane_st[2] = SEED2;
    lane_st[3] = SEED3;
    len_st = '0;
  endfunction

  // Updates the lane state with one chunk and returns 1 when the message ends.
  function automatic bit absorb_chunk(input chunk_t c, output lanes_t digest);
    lanes_t      prime_set;
    logic [4:0]  n;
    logic [7:0]  b;
    int unsigned lane;
    int unsigned k;
    prime_set[0] = PRIME0;
    prime_set[1] = PRIME1;
    prime_set[2] = PRIME2;
    prime_set[3] = PRIME3;
    digest = '0;
    n = (c.nbytes > CHUNK_BYTES) ? CHUNK_BYTES : c.nbytes;
    if (!c.last) begin
      n = CHUNK_BYTES;
    end
    len_st = len_st + n;
    if (n == CHUNK_BYTES) begin
      for (int i = 0; i < 4; i++) begin
        lane_st[i] = ((lane_st[i] ^ c.words[i]) * prime_set[i]) + c.words[(i + 1) % 4];
      end
    end else begin
      lane = 0;
      k = 0;
      while (k + 4 <= n) begin
        lane_st[lane] = (lane_st[lane] ^ c.words[k >> 2]) * FNV_PRIME;
        lane = (lane + 1) % 4;
        k += 4;
      end
      while (k < n) begin
        b = c.words[k >> 2][(k % 4) * 8 +: 8];
        lane_st[lane] = (lane_st[lane] ^ {24'd0, b}) * FNV_PRIME;
        lane = (lane + 1) % 4;
        k++;
      end
    end
    if (!c.last) begin
      return 1'b0;
    end
    digest[0] = lane_st[0] ^ (len_st * MIX0);
    digest[1] = lane_st[1] ^ {len_st[24:0], len_st[31:25]};
    digest[2] = lane_st[2] ^ (len_st * MIX2);
    digest[3] = lane_st[3] ^ (len_st * MIX3);
    reload_lanes();
    return 1'b1;
  endfunction

  function automatic lanes_t rand_words();
    lanes_t w;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(9))
        0: w[i] = '0;
        1: w[i] = '1;
        default: w[i] = $urandom;
      endcase
    end
    return w;
  endfunction

  task automatic push_chunk(input lanes_t w, input logic [4:0] n, input bit last,
                            input int gap, input int stall, input bit drain);
    chunk_t c;
    c.words = w;
    c.nbytes = n;
    c.last = last;
    c.gap_pct = gap;
    c.stall_pct = stall;
    c.drain_first = drain;
    chunk_q.push_back(c);
    chunks_queued++;
  endtask

  // Well-formed message with random content; some chunks carry odd byte counts.
  task automatic push_message(input int gap, input int stall, input bit drain);
    int          body;
    logic [4:0]  n;
    body = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(4);
    for (int j = 0; j <= body; j++) begin
      if (j == body) begin
        n = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
      end else begin
        n = ($urandom_range(7) == 0) ? 5'($urandom) : CHUNK_BYTES;
      end
      push_chunk(rand_words(), n, j == body, gap, stall, drain && j == 0);
    end
  endtask

  always @(posedge clk) begin
    lanes_t digest;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      reload_lanes();
    end else begin
      if (in_tvalid && in_tready) begin
        if (absorb_chunk(sent_chunk, digest)) begin
          digest_q.push_back(digest);
        end
      end
      if (!in_tvalid || in_tready) begin
        if (chunk_q.size() != 0 && !(chunk_q[0].drain_first && digest_q.size() != 0) &&
            $urandom_range(99) >= chunk_q[0].gap_pct) begin
          sent_chunk = chunk_q.pop_front();
          stall_pct <= sent_chunk.stall_pct;
          in_tdata <= {3'b000, sent_chunk.nbytes, sent_chunk.words};
          in_tlast <= sent_chunk.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    lanes_t got;
    lanes_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result transaction: %h", got);
          end
        end else begin
          want = digest_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              fail_count++;
              if (fail_count <= 10) begin
                $display("hash%0d mismatch: expected %h, actual %h", i, want[i], got[i]);
              end
            end
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[four_lane_fnv_block_hash] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    int          short_counts[7] = '{1, 3, 4, 5, 8, 12, 15};
    int          gaps[4] = '{0, 52, 0, 15};
    int          stalls[4] = '{0, 0, 52, 15};
    int unsigned target;
    push_chunk('0, 5'd0, 1'b1, 0, 0, 1'b0);
    push_chunk('1, CHUNK_BYTES, 1'b1, 0, 0, 1'b0);
    foreach (short_counts[i]) begin
      push_chunk(rand_words(), 5'(short_counts[i]), 1'b1, 0, 0, 1'b0);
    end
    push_chunk(rand_words(), 5'd31, 1'b1, 0, 0, 1'b0);
    push_chunk(rand_words(), 5'd17, 1'b1, 0, 0, 1'b0);
    push_chunk(rand_words(), 5'd0, 1'b0, 0, 0, 1'b0);
    push_chunk(rand_words(), 5'd7, 1'b1, 0, 0, 1'b0);
    push_chunk('0, 5'd31, 1'b0, 0, 0, 1'b0);
    push_chunk('1, 5'd9, 1'b0, 0, 0, 1'b0);
    push_chunk(rand_words(), CHUNK_BYTES, 1'b1, 0, 0, 1'b0);
    push_chunk(rand_words(), CHUNK_BYTES, 1'b0, 0, 0, 1'b0);
    push_chunk(rand_words(), CHUNK_BYTES, 1'b0, 0, 0, 1'b0);
    push_chunk(rand_words(), 5'd0, 1'b1, 0, 0, 1'b0);
    for (int p = 0; p < 4; p++) begin
      target = chunks_queued + PHASE_ITEMS;
      push_message(gaps[p], stalls[p], 1'b1);
      while (chunks_queued < target) begin
        push_message(gaps[p], stalls[p], 1'b0);
      end
    end
    while (chunk_q.size() != 0 || in_tvalid || digest_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("[four_lane_fnv_block_hash] OK");
    end else begin
      $display("[four_lane_fnv_block_hash] ERROR");
    end
    $finish;
  end

endmodule
